// File: rtl/wgc_pkg.sv
package wgc_pkg;

    localparam int NUM_AXES    = 3;
    localparam int GRAIN_W     = 4;
    localparam int CFG_W       = 5;
    localparam int POS_W       = 16;
    localparam int IN_W        = 16;
    localparam int WC_W        = 32;
    localparam int MASS_W      = 48;
    localparam int MOM_W       = 64;
    localparam int QUOT_W      = 17;
    localparam int STEP_W      = $clog2(QUOT_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] NUM_GRAINS_RESET = 5'd16;
    localparam logic [POS_W-1:0] CENTER_POS_MAX   = 16'h7fff;
    localparam logic [POS_W-1:0] CENTER_NEG_MAX   = 16'h8000;

    typedef logic [NUM_AXES-1:0][POS_W-1:0]  pos_vec_t;
    typedef logic [NUM_AXES-1:0][MOM_W-1:0]  mom_vec_t;
    typedef logic [NUM_AXES-1:0][QUOT_W-1:0] quot_vec_t;

    // one classified sample waiting for the accumulator
    typedef struct packed {
        logic               acc;
        logic [GRAIN_W-1:0] grain;
        logic [WC_W-1:0]    wc;
        logic [IN_W-1:0]    eta;
        pos_vec_t           pos;
        logic               eop;
    } q_entry_t;

    // one accumulator row
    typedef struct packed {
        logic [MASS_W-1:0] mass;
        mom_vec_t          mom;
    } acc_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/wgc_front.sv
module wgc_front
    import wgc_pkg::*;
#(
    parameter int MAX_GRAINS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [$clog2(MAX_GRAINS + 1)-1:0] n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [GRAIN_W-1:0]        grain_index,
    input  logic [IN_W-1:0]           quad_weight,
    input  logic [IN_W-1:0]           coord_factor,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic [IN_W-1:0]           order_value,
    input  logic                      end_of_pass,
    output logic                      push,
    output q_entry_t                  entry,
    input  logic                      q_ready
);

    logic                fv_reg;
    logic                fv_next;
    logic                take;
    logic [GRAIN_W-1:0]  g_reg;
    logic [IN_W-1:0]     w_reg;
    logic [IN_W-1:0]     c_reg;
    logic [IN_W-1:0]     eta_reg;
    pos_vec_t            pos_reg;
    logic                eop_reg;

    assign in_ready = !fv_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign push     = fv_reg;

    always_comb
    begin
        fv_next = fv_reg;
        if (take)
        begin
            fv_next = 1'b1;
        end
        else if (q_ready)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            g_reg   <= grain_index;
            w_reg   <= quad_weight;
            c_reg   <= coord_factor;
            eta_reg <= order_value;
            pos_reg <= {pos_z, pos_y, pos_x};
            eop_reg <= end_of_pass;
        end
    end

    // classify: only grains below the effective count accumulate
    always_comb
    begin
        entry.acc   = ({3'b000, g_reg} < 7'(n));
        entry.grain = g_reg;
        entry.wc    = w_reg * c_reg;
        entry.eta   = eta_reg;
        entry.pos   = pos_reg;
        entry.eop   = eop_reg;
    end

endmodule

// File: rtl/wgc_queue.sv
module wgc_queue
    import wgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t entry,
    output logic     q_ready,
    input  logic     pop,
    output logic     q_valid,
    output q_entry_t head
);

    q_entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic                wr;
    logic                rd;

    assign q_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign wr      = push && q_ready;
    assign rd      = pop && q_valid;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

// File: rtl/wgc_div.sv
module wgc_div
    import wgc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MASS_W-1:0]   mass,
    input  mom_vec_t            mag,
    output div_stat_t           stat,
    output quot_vec_t           quot,
    output logic [NUM_AXES-1:0] big
);

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [MOM_W-1:0]    d_reg;
    mom_vec_t            r_reg;
    quot_vec_t           q_reg;
    logic [NUM_AXES-1:0] big_reg;

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (step_reg == '0);
    assign quot      = q_reg;
    assign big       = big_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(QUOT_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle on all three lanes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg <= {mass, (QUOT_W - 1)'(0)};
            q_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                r_reg[i]   <= mag[i];
                big_reg[i] <= ({1'b0, mag[i]} >= {mass, QUOT_W'(0)});
            end
        end
        else if (busy_reg)
        begin
            d_reg <= d_reg >> 1;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (r_reg[i] >= d_reg)
                begin
                    r_reg[i] <= r_reg[i] - d_reg;
                    q_reg[i] <= {q_reg[i][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[i] <= {q_reg[i][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

// File: rtl/wgc_back.sv
module wgc_back
    import wgc_pkg::*;
#(
    parameter int MAX_GRAINS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [$clog2(MAX_GRAINS + 1)-1:0] n,
    input  logic                      q_valid,
    input  q_entry_t                  head,
    output logic                      pop,
    output logic                      div_start,
    output logic [MASS_W-1:0]         div_mass,
    output mom_vec_t                  div_mag,
    input  div_stat_t                 div_stat,
    input  quot_vec_t                 div_quot,
    input  logic [NUM_AXES-1:0]       div_big,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [GRAIN_W-1:0]        out_grain,
    output logic signed [POS_W-1:0]   center_x,
    output logic signed [POS_W-1:0]   center_y,
    output logic signed [POS_W-1:0]   center_z,
    output logic                      zero_mass,
    output logic                      last_grain
);

    localparam int CW = $clog2(MAX_GRAINS + 1);
    localparam int GW = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int IW = (GW > GRAIN_W) ? GW : GRAIN_W;
    localparam int KW = (CW > GRAIN_W) ? CW : GRAIN_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_T        = 8'b0000_0010,
        S_PROD     = 8'b0000_0100,
        S_WRITE    = 8'b0000_1000,
        S_RPT_RD   = 8'b0001_0000,
        S_RPT_WAIT = 8'b0010_0000,
        S_DIV      = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       k_next;
    logic                out_valid_reg;
    logic                out_free;
    logic                out_load;
    logic                is_last;
    logic                clear_all;

    acc_entry_t          mem [MAX_GRAINS];
    logic [MAX_GRAINS-1:0] vld_reg;
    logic                rd_en;
    logic [GW-1:0]       rd_addr;
    acc_entry_t          rd_data_reg;
    logic                rd_vld_reg;
    acc_entry_t          cur;
    logic                mem_we;
    logic [GW-1:0]       wr_addr;
    acc_entry_t          wr_data;

    q_entry_t            item_reg;
    logic [MASS_W-1:0]   t_reg;
    mom_vec_t            prod_reg;
    logic [NUM_AXES-1:0] neg_reg;
    logic                zero_reg;

    logic [IW-1:0]       head_ext;
    logic [IW-1:0]       item_ext;
    logic [KW-1:0]       k_ext;

    logic [GRAIN_W-1:0]  out_grain_reg;
    pos_vec_t            center_reg;
    logic                zero_mass_reg;
    logic                last_reg;

    function automatic logic [POS_W-1:0] sat_center(
        input logic              neg,
        input logic              big,
        input logic [QUOT_W-1:0] q
    );
        logic [POS_W-1:0] r;
        if (neg)
        begin
            r = (big || q > QUOT_W'(32768)) ? CENTER_NEG_MAX : POS_W'(-q);
        end
        else
        begin
            r = (big || q > QUOT_W'(32767)) ? CENTER_POS_MAX : q[POS_W-1:0];
        end
        return r;
    endfunction

    assign head_ext = IW'(head.grain);
    assign item_ext = IW'(item_reg.grain);
    assign k_ext    = KW'(k_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = (CW'(k_reg + 1'b1) == n);
    assign cur      = rd_vld_reg ? rd_data_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = head_ext[GW-1:0];
        div_start  = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        clear_all  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    rd_en      = 1'b1;
                    state_next = S_T;
                end
            end
            S_T:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we = item_reg.acc;
                if (item_reg.eop)
                begin
                    k_next     = '0;
                    state_next = S_RPT_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RPT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[GW-1:0];
                state_next = S_RPT_WAIT;
            end
            S_RPT_WAIT:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        clear_all  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_RPT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_all)
            begin
                vld_reg <= '0;
            end
            else if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // accumulator store, one read and one write port
    assign wr_addr = item_ext[GW-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // saturating update of mass and moments
    always_comb
    begin
        logic [MASS_W:0] m;
        logic [MOM_W:0]  s;
        m = {1'b0, cur.mass} + {1'b0, t_reg};
        wr_data.mass = m[MASS_W] ? {MASS_W{1'b1}} : m[MASS_W-1:0];
        for (int i = 0; i < NUM_AXES; i++)
        begin
            s = {cur.mom[i][MOM_W-1], cur.mom[i]} + {prod_reg[i][MOM_W-1], prod_reg[i]};
            if (s[MOM_W] != s[MOM_W-1])
            begin
                wr_data.mom[i] = s[MOM_W] ? {1'b1, {(MOM_W-1){1'b0}}}
                                          : {1'b0, {(MOM_W-1){1'b1}}};
            end
            else
            begin
                wr_data.mom[i] = s[MOM_W-1:0];
            end
        end
    end

    // divider operands: magnitude of each moment over the mass
    always_comb
    begin
        div_mass = cur.mass;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            div_mag[i] = cur.mom[i][MOM_W-1] ? (MOM_W'(0) - cur.mom[i]) : cur.mom[i];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [MOM_W:0] p;
        if (pop)
        begin
            item_reg <= head;
        end
        if (state_reg == S_T)
        begin
            t_reg <= item_reg.wc * item_reg.eta;
        end
        if (state_reg == S_PROD)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                p = $signed({1'b0, t_reg}) * $signed(item_reg.pos[i]);
                prod_reg[i] <= p[MOM_W-1:0];
            end
        end
        if (div_start)
        begin
            zero_reg <= (cur.mass == '0);
            for (int i = 0; i < NUM_AXES; i++)
            begin
                neg_reg[i] <= cur.mom[i][MOM_W-1];
            end
        end
        if (out_load)
        begin
            out_grain_reg <= k_ext[GRAIN_W-1:0];
            zero_mass_reg <= zero_reg;
            last_reg      <= is_last;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                center_reg[i] <= zero_reg ? '0
                                          : sat_center(neg_reg[i], div_big[i], div_quot[i]);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_grain  = out_grain_reg;
    assign center_x   = $signed(center_reg[0]);
    assign center_y   = $signed(center_reg[1]);
    assign center_z   = $signed(center_reg[2]);
    assign zero_mass  = zero_mass_reg;
    assign last_grain = last_reg;

    a_rpt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT || state_reg == S_RPT_RD) |-> (k_reg < n))
        else $error("report index past grain count");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == S_IDLE && vld_reg == '0))
        else $error("report end did not clear and return idle");

endmodule

// File: rtl/weighted_grain_centroid_core.sv
// weighted grain centroid core
// input channel (in_valid / in_ready): one sample per transfer with its grain,
// weight, coordinate factor, position and order value; end_of_pass marks the
// last sample of a pass
// output channel (out_valid / out_ready): one centroid per transfer, grains
// 0 .. n-1 in order, last_grain set on the final one of each report
// config: cfg_wr_en writes num_grains from cfg_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce;
// 0 acts as 1, above MAX_GRAINS acts as MAX_GRAINS; the sequencer takes
// one sample at a time: pop/read, weight product, moment products and
// saturating write back; a sample passes the input, queue, item, weight
// product and moment product registers before the accumulator update;
// report: each grain reads its row and runs the 17 step shared divider;
// a 4 entry queue sits between the input stage and the sequencer, so inputs
// keep flowing while a report runs until the queue fills
// when the receiver stalls the result holds in the output register and
// the report waits; reset empties the queue, clears all accumulators and
// sets num_grains to 16
module weighted_grain_centroid_core
    import wgc_pkg::*;
#(
    parameter int MAX_GRAINS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [GRAIN_W-1:0]        grain_index,
    input  logic [IN_W-1:0]           quad_weight,
    input  logic [IN_W-1:0]           coord_factor,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    input  logic [IN_W-1:0]           order_value,
    input  logic                      end_of_pass,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [GRAIN_W-1:0]        out_grain,
    output logic signed [POS_W-1:0]   center_x,
    output logic signed [POS_W-1:0]   center_y,
    output logic signed [POS_W-1:0]   center_z,
    output logic                      zero_mass,
    output logic                      last_grain
);

    localparam int CW = $clog2(MAX_GRAINS + 1);
    localparam logic [6:0] MAXG = 7'(MAX_GRAINS);

    logic [CFG_W-1:0]    num_grains_reg;
    logic [6:0]          ng_ext;
    logic [6:0]          n_ext;
    logic [CW-1:0]       n;

    logic                push;
    q_entry_t            entry;
    logic                q_ready;
    logic                q_valid;
    q_entry_t            head;
    logic                pop;

    logic                div_start;
    logic [MASS_W-1:0]   div_mass;
    mom_vec_t            div_mag;
    div_stat_t           div_stat;
    quot_vec_t           div_quot;
    logic [NUM_AXES-1:0] div_big;

    // grain count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_grains_reg <= NUM_GRAINS_RESET;
        end
        else if (cfg_wr_en)
        begin
            num_grains_reg <= cfg_wr_data;
        end
    end

    // effective grain count, clamped to 1 .. MAX_GRAINS
    always_comb
    begin
        ng_ext = {2'b00, num_grains_reg};
        if (ng_ext == '0)
        begin
            n_ext = 7'd1;
        end
        else if (ng_ext > MAXG)
        begin
            n_ext = MAXG;
        end
        else
        begin
            n_ext = ng_ext;
        end
    end

    assign n = n_ext[CW-1:0];

    // input stage: registers the sample, checks the grain, forms w * c
    wgc_front #(
        .MAX_GRAINS (MAX_GRAINS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .n            (n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .grain_index  (grain_index),
        .quad_weight  (quad_weight),
        .coord_factor (coord_factor),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .order_value  (order_value),
        .end_of_pass  (end_of_pass),
        .push         (push),
        .entry        (entry),
        .q_ready      (q_ready)
    );

    // decoupling queue between input stage and sequencer
    wgc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .entry   (entry),
        .q_ready (q_ready),
        .pop     (pop),
        .q_valid (q_valid),
        .head    (head)
    );

    // shared three lane divider for the report
    wgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mass  (div_mass),
        .mag   (div_mag),
        .stat  (div_stat),
        .quot  (div_quot),
        .big   (div_big)
    );

    // accumulate and report sequencer with the accumulator store
    wgc_back #(
        .MAX_GRAINS (MAX_GRAINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .n          (n),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .div_start  (div_start),
        .div_mass   (div_mass),
        .div_mag    (div_mag),
        .div_stat   (div_stat),
        .div_quot   (div_quot),
        .div_big    (div_big),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_grain  (out_grain),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .zero_mass  (zero_mass),
        .last_grain (last_grain)
    );

endmodule
